### rtl/acm_pkg.sv
// Package for the affine transform-matrix engine: word type, operation codes,
// saturating fixed-point helpers, lane and merge control structs, CORDIC table.
// No dependencies.
package acm_pkg;

  localparam int WORD_W       = 32;
  localparam int FRAC_W       = 16;
  localparam int DIV_W        = WORD_W + FRAC_W;
  localparam int N_LANES      = 4;
  localparam int CORDIC_STEPS = 24;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [3:0] func_t;

  localparam func_t F_INIT        = 4'd0;
  localparam func_t F_SET         = 4'd1;
  localparam func_t F_CURRENT     = 4'd2;
  localparam func_t F_TRANSLATE   = 4'd3;
  localparam func_t F_SCALE       = 4'd4;
  localparam func_t F_ROTATE      = 4'd5;
  localparam func_t F_CONCAT      = 4'd6;
  localparam func_t F_TRANSFORM   = 4'd7;
  localparam func_t F_DTRANSFORM  = 4'd8;
  localparam func_t F_ITRANSFORM  = 4'd9;
  localparam func_t F_IDTRANSFORM = 4'd10;
  localparam func_t F_INVERT      = 4'd11;

  localparam word_t W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t W_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam word_t W_ONE = word_t'(64'd1 << FRAC_W);

  typedef struct packed {
    logic mul_en;
    logic div_start;
  } lane_ctl_t;

  typedef struct packed {
    logic en;
    logic neg1;
    logic add_e;
    logic neg_out;
  } mrg_ctl_t;

  function automatic word_t ident(input int j);
    return (j == 0 || j == 3) ? W_ONE : '0;
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b);
    logic signed [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) begin
      return s[WORD_W] ? W_MIN : W_MAX;
    end
    return s[WORD_W-1:0];
  endfunction

  function automatic word_t sneg(input word_t a);
    return (a == W_MIN) ? W_MAX : -a;
  endfunction

  function automatic logic [WORD_W-1:0] mag(input word_t a);
    return a[WORD_W-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic word_t from_mag(input logic neg, input logic [63:0] m);
    if (m > 64'(W_MAX)) begin
      return neg ? W_MIN : W_MAX;
    end
    return neg ? word_t'(~m[WORD_W-1:0] + 1'b1) : word_t'(m[WORD_W-1:0]);
  endfunction

  function automatic word_t qmul(input word_t a, input word_t b);
    logic [63:0] p;
    logic [63:0] r;
    p = 64'(mag(a)) * 64'(mag(b));
    r = (p + (64'd1 << (FRAC_W-1))) >> FRAC_W;
    return from_mag(a[WORD_W-1] ^ b[WORD_W-1], r);
  endfunction

  // Arctangent of 2^-i in degrees with 24 fraction bits.
  function automatic logic [31:0] atan_deg(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd754974720;
      5'd1:  v = 32'd445687602;
      5'd2:  v = 32'd235489088;
      5'd3:  v = 32'd119537938;
      5'd4:  v = 32'd60000934;
      5'd5:  v = 32'd30029717;
      5'd6:  v = 32'd15018523;
      5'd7:  v = 32'd7509720;
      5'd8:  v = 32'd3754917;
      5'd9:  v = 32'd1877466;
      5'd10: v = 32'd938734;
      5'd11: v = 32'd469367;
      5'd12: v = 32'd234684;
      5'd13: v = 32'd117342;
      5'd14: v = 32'd58671;
      5'd15: v = 32'd29335;
      5'd16: v = 32'd14668;
      5'd17: v = 32'd7334;
      5'd18: v = 32'd3667;
      5'd19: v = 32'd1833;
      5'd20: v = 32'd917;
      5'd21: v = 32'd458;
      5'd22: v = 32'd229;
      5'd23: v = 32'd115;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/acm_if.sv
// Valid/ready channel interfaces for the engine's operation and result streams.
// Depends on acm_pkg.
interface acm_in_if import acm_pkg::*; ();
  logic  valid;
  logic  ready;
  func_t func;
  logic  use_supplied;
  word_t mat_a;
  word_t mat_b;
  word_t mat_c;
  word_t mat_d;
  word_t mat_tx;
  word_t mat_ty;
  word_t arg_x;
  word_t arg_y;

  modport source (output valid, func, use_supplied, mat_a, mat_b, mat_c, mat_d,
                  mat_tx, mat_ty, arg_x, arg_y, input ready);
  modport sink (input valid, func, use_supplied, mat_a, mat_b, mat_c, mat_d,
                mat_tx, mat_ty, arg_x, arg_y, output ready);
endinterface

interface acm_out_if import acm_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t res_a;
  word_t res_b;
  word_t res_c;
  word_t res_d;
  word_t res_tx;
  word_t res_ty;
  logic  status;

  modport source (output valid, res_a, res_b, res_c, res_d, res_tx, res_ty, status,
                  input ready);
  modport sink (input valid, res_a, res_b, res_c, res_d, res_tx, res_ty, status,
                output ready);
endinterface

### rtl/acm_lane.sv
// One arithmetic lane: a registered rounding fixed-point multiplier and a
// one-bit-per-cycle restoring divider with rounding. Depends on acm_pkg.
module acm_lane import acm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lane_ctl_t ctl,
  input  word_t     op_a,
  input  word_t     op_b,
  output word_t     prod,
  output word_t     quo,
  output logic      busy
);

  localparam int CNT_W = $clog2(DIV_W);

  word_t             prod_r;
  logic [DIV_W-1:0]  num_r;
  logic [DIV_W-1:0]  quo_r;
  logic [WORD_W-1:0] den_r;
  logic [WORD_W-1:0] rem_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;

  logic [WORD_W:0]   rem_sh;
  logic              ge;
  logic [WORD_W-1:0] rem_nxt;
  logic              rnd;

  assign rem_sh  = {rem_r, num_r[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? WORD_W'(rem_sh - {1'b0, den_r}) : rem_sh[WORD_W-1:0];
  assign rnd     = rem_r >= (den_r - rem_r);

  assign prod = prod_r;
  assign quo  = from_mag(neg_r, 64'(quo_r) + 64'(rnd));
  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      if (ctl.mul_en) begin
        prod_r <= qmul(op_a, op_b);
      end
      if (ctl.div_start) begin
        num_r  <= {mag(op_a), {FRAC_W{1'b0}}};
        den_r  <= mag(op_b);
        rem_r  <= '0;
        quo_r  <= '0;
        neg_r  <= op_a[WORD_W-1] ^ op_b[WORD_W-1];
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        num_r <= {num_r[DIV_W-2:0], 1'b0};
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W-1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

### rtl/acm_merge.sv
// Merging stage: combines the four lane products into two saturated sums,
// with optional negation and translation terms. Depends on acm_pkg.
module acm_merge import acm_pkg::*; (
  input  logic     clk,
  input  mrg_ctl_t ctl,
  input  word_t    prod [N_LANES],
  input  word_t    add0,
  input  word_t    add1,
  output word_t    r0,
  output word_t    r1
);

  word_t r0_r;
  word_t r1_r;
  word_t s0;
  word_t s1;

  assign s0 = sadd(sadd(prod[0], ctl.neg1 ? sneg(prod[1]) : prod[1]), ctl.add_e ? add0 : '0);
  assign s1 = sadd(sadd(prod[2], prod[3]), ctl.add_e ? add1 : '0);

  assign r0 = r0_r;
  assign r1 = r1_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      r0_r <= ctl.neg_out ? sneg(s0) : s0;
      r1_r <= ctl.neg_out ? sneg(s1) : s1;
    end
  end

endmodule

### rtl/acm_cordic.sv
// Sine and cosine of an angle in degrees: modulo-360 reduction, folding into
// [-90,90] and 24 CORDIC rotations, one per cycle. Depends on acm_pkg.
module acm_cordic import acm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t deg,
  output logic  busy,
  output word_t sin_v,
  output word_t cos_v
);

  localparam int ANG_W  = 35;
  localparam int XY_W   = 34;
  localparam int ANG_SH = 24 - FRAC_W;
  localparam int OUT_SH = 30 - FRAC_W;
  localparam logic [WORD_W-1:0]     RED_FULL = WORD_W'(360 << FRAC_W);
  localparam logic signed [ANG_W-1:0] ANG_90  = 35'sd1509949440;
  localparam logic signed [ANG_W-1:0] ANG_180 = 35'sd3019898880;
  localparam logic signed [ANG_W-1:0] ANG_360 = 35'sd6039797760;
  localparam logic signed [XY_W-1:0]  GAIN    = 34'sd652032874;

  typedef enum logic [2:0] {C_IDLE, C_RED, C_FOLD, C_ROT, C_OUT} cst_t;

  cst_t                     st_r;
  logic                     neg_r;
  logic [WORD_W-1:0]        r_r;
  logic [2:0]               k_r;
  logic [4:0]               i_r;
  logic signed [ANG_W-1:0]  z_r;
  logic signed [XY_W-1:0]   x_r;
  logic signed [XY_W-1:0]   y_r;
  logic                     flip_r;
  word_t                    sin_r;
  word_t                    cos_r;

  logic [WORD_W-1:0]        red_sub;
  logic [WORD_W-1:0]        a_red;
  logic signed [ANG_W-1:0]  z0;
  logic signed [ANG_W-1:0]  z1;
  logic signed [XY_W-1:0]   dx;
  logic signed [XY_W-1:0]   dy;
  logic signed [ANG_W-1:0]  at;
  logic signed [XY_W-1:0]   xf;

  function automatic word_t q30_out(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] r;
    r = (v + (XY_W'(1) <<< (OUT_SH-1))) >>> OUT_SH;
    if (r > XY_W'(W_MAX)) begin
      return W_MAX;
    end
    if (r < -(XY_W'(W_MAX)) - 1) begin
      return W_MIN;
    end
    return r[WORD_W-1:0];
  endfunction

  assign red_sub = RED_FULL << k_r;
  assign a_red   = (neg_r && r_r != '0) ? RED_FULL - r_r : r_r;
  assign z0      = $signed({{(ANG_W-WORD_W){1'b0}}, a_red}) <<< ANG_SH;
  assign z1      = (z0 > ANG_180) ? z0 - ANG_360 : z0;
  assign dx      = y_r >>> i_r;
  assign dy      = x_r >>> i_r;
  assign at      = $signed({{(ANG_W-WORD_W){1'b0}}, atan_deg(i_r)});
  assign xf      = flip_r ? -x_r : x_r;

  assign busy  = st_r != C_IDLE;
  assign sin_v = sin_r;
  assign cos_v = cos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
    end else begin
      case (st_r)
        C_IDLE: begin
          if (start) begin
            neg_r <= deg[WORD_W-1];
            r_r   <= mag(deg);
            k_r   <= 3'd7;
            st_r  <= C_RED;
          end
        end
        C_RED: begin
          if (r_r >= red_sub) begin
            r_r <= r_r - red_sub;
          end
          k_r <= k_r - 1'b1;
          if (k_r == 3'd0) begin
            st_r <= C_FOLD;
          end
        end
        C_FOLD: begin
          if (z1 > ANG_90) begin
            z_r    <= ANG_180 - z1;
            flip_r <= 1'b1;
          end else if (z1 < -ANG_90) begin
            z_r    <= -ANG_180 - z1;
            flip_r <= 1'b1;
          end else begin
            z_r    <= z1;
            flip_r <= 1'b0;
          end
          x_r  <= GAIN;
          y_r  <= '0;
          i_r  <= '0;
          st_r <= C_ROT;
        end
        C_ROT: begin
          if (z_r >= 0) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + at;
          end
          i_r <= i_r + 1'b1;
          if (i_r == 5'(CORDIC_STEPS-1)) begin
            st_r <= C_OUT;
          end
        end
        C_OUT: begin
          sin_r <= q30_out(y_r);
          cos_r <= q30_out(xf);
          st_r  <= C_IDLE;
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

endmodule

### rtl/affine_ctm_engine_top.sv
// Top level of the affine transform-matrix engine: sequencer, matrix state,
// four arithmetic lanes, merging stage and CORDIC unit. Depends on acm_pkg, acm_if,
// acm_lane, acm_merge and acm_cordic.
//
//   channel | direction | handshake    | carries
//   in_ch   | in        | valid/ready  | func, use_supplied, mat_a..mat_ty, arg_x, arg_y
//   out_ch  | out       | valid/ready  | res_a..res_ty, status
//
// One operation is in work at a time. Init, set, current and unused codes go
// straight to the result; translate, scale and concat run multiply-merge
// passes; rotate first runs the reduction and 24 CORDIC steps; point maps run
// a pass; inversions wait for the divider in each lane. The result register
// lets the next transfer in while a result waits. Reset (rst_n low,
// synchronous) restores the identity matrix and its valid inverse.
module affine_ctm_engine_top import acm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  acm_in_if.sink   in_ch,
  acm_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CORDIC_GO, S_CORDIC_WAIT, S_PASS_MUL, S_PASS_MRG,
    S_PASS_WB, S_MAT_END, S_DET_MUL, S_DET_MRG, S_DET_CHK, S_DIV_GO, S_DIV_WAIT,
    S_INV_DONE, S_FIN
  } state_t;

  typedef enum logic [1:0] {J_MAT, J_MAP, J_INVT} job_t;

  state_t state_r;
  job_t   job_r;
  func_t  func_r;
  logic   sup_r;
  word_t  x_r;
  word_t  y_r;
  word_t  m_r   [6];
  word_t  cur_r [6];
  word_t  inv_r [6];
  word_t  src_r [6];
  word_t  t_r   [6];
  word_t  res_r [6];
  word_t  out_res_r [6];
  logic   inv_valid_r;
  logic   st_r;
  logic   out_st_r;
  logic   out_valid_r;
  logic   wr_cur_r;
  logic   add_r;
  logic [1:0] coef_r;
  logic [1:0] dst_r;
  word_t  det_r;

  lane_ctl_t lane_ctl;
  mrg_ctl_t  mrg_ctl;
  word_t     lane_a    [N_LANES];
  word_t     lane_b    [N_LANES];
  word_t     lane_prod [N_LANES];
  word_t     lane_quo  [N_LANES];
  logic [N_LANES-1:0] lane_busy;
  word_t     mrg_r0;
  word_t     mrg_r1;
  word_t     cp;
  word_t     cq;
  logic      cordic_busy;
  word_t     sin_v;
  word_t     cos_v;

  for (genvar g = 0; g < N_LANES; g++) begin : g_lane
    acm_lane u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (lane_ctl),
      .op_a (lane_a[g]),
      .op_b (lane_b[g]),
      .prod (lane_prod[g]),
      .quo  (lane_quo[g]),
      .busy (lane_busy[g])
    );
  end

  acm_merge u_merge (
    .clk (clk),
    .ctl (mrg_ctl),
    .prod(lane_prod),
    .add0(src_r[4]),
    .add1(src_r[5]),
    .r0  (mrg_r0),
    .r1  (mrg_r1)
  );

  acm_cordic u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .start(state_r == S_CORDIC_GO),
    .deg  (x_r),
    .busy (cordic_busy),
    .sin_v(sin_v),
    .cos_v(cos_v)
  );

  always_comb begin
    lane_ctl = '0;
    mrg_ctl  = '0;
    for (int j = 0; j < N_LANES; j++) begin
      lane_a[j] = '0;
      lane_b[j] = '0;
    end
    case (coef_r)
      2'd0: begin
        cp = t_r[0];
        cq = t_r[1];
      end
      2'd1: begin
        cp = t_r[2];
        cq = t_r[3];
      end
      default: begin
        cp = t_r[4];
        cq = t_r[5];
      end
    endcase
    case (state_r)
      S_PASS_MUL: begin
        lane_ctl.mul_en = 1'b1;
        lane_a[0] = cp;
        lane_b[0] = src_r[0];
        lane_a[1] = cq;
        lane_b[1] = src_r[2];
        lane_a[2] = cp;
        lane_b[2] = src_r[1];
        lane_a[3] = cq;
        lane_b[3] = src_r[3];
      end
      S_PASS_MRG: begin
        mrg_ctl.en      = 1'b1;
        mrg_ctl.add_e   = (job_r == J_MAT) ? (coef_r == 2'd2) : add_r;
        mrg_ctl.neg_out = job_r == J_INVT;
      end
      S_DET_MUL: begin
        lane_ctl.mul_en = 1'b1;
        lane_a[0] = src_r[0];
        lane_b[0] = src_r[3];
        lane_a[1] = src_r[1];
        lane_b[1] = src_r[2];
      end
      S_DET_MRG: begin
        mrg_ctl.en   = 1'b1;
        mrg_ctl.neg1 = 1'b1;
      end
      S_DIV_GO: begin
        lane_ctl.div_start = 1'b1;
        lane_a[0] = src_r[3];
        lane_a[1] = src_r[1];
        lane_a[2] = src_r[2];
        lane_a[3] = src_r[0];
        for (int j = 0; j < N_LANES; j++) begin
          lane_b[j] = det_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready   = state_r == S_IDLE;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.res_a  = out_res_r[0];
  assign out_ch.res_b  = out_res_r[1];
  assign out_ch.res_c  = out_res_r[2];
  assign out_ch.res_d  = out_res_r[3];
  assign out_ch.res_tx = out_res_r[4];
  assign out_ch.res_ty = out_res_r[5];
  assign out_ch.status = out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      inv_valid_r <= 1'b1;
      out_valid_r <= 1'b0;
      for (int j = 0; j < 6; j++) begin
        cur_r[j] <= ident(j);
        inv_r[j] <= ident(j);
      end
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            func_r  <= in_ch.func;
            sup_r   <= in_ch.use_supplied;
            m_r[0]  <= in_ch.mat_a;
            m_r[1]  <= in_ch.mat_b;
            m_r[2]  <= in_ch.mat_c;
            m_r[3]  <= in_ch.mat_d;
            m_r[4]  <= in_ch.mat_tx;
            m_r[5]  <= in_ch.mat_ty;
            x_r     <= in_ch.arg_x;
            y_r     <= in_ch.arg_y;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          st_r   <= 1'b0;
          job_r  <= (func_r == F_TRANSFORM || func_r == F_DTRANSFORM) ? J_MAP : J_MAT;
          coef_r <= 2'd0;
          dst_r  <= 2'd0;
          add_r  <= func_r == F_TRANSFORM;
          case (func_r)
            F_INIT: begin
              for (int j = 0; j < 6; j++) begin
                res_r[j] <= ident(j);
                if (!sup_r) begin
                  cur_r[j] <= ident(j);
                  inv_r[j] <= ident(j);
                end
              end
              if (!sup_r) begin
                inv_valid_r <= 1'b1;
              end
              state_r <= S_FIN;
            end
            F_SET: begin
              for (int j = 0; j < 6; j++) begin
                cur_r[j] <= m_r[j];
                res_r[j] <= m_r[j];
              end
              inv_valid_r <= 1'b0;
              state_r     <= S_FIN;
            end
            F_CURRENT: begin
              for (int j = 0; j < 6; j++) begin
                res_r[j] <= cur_r[j];
              end
              state_r <= S_FIN;
            end
            F_TRANSLATE, F_SCALE, F_ROTATE: begin
              for (int j = 0; j < 6; j++) begin
                src_r[j] <= sup_r ? m_r[j] : cur_r[j];
                if (func_r == F_TRANSLATE && j >= 4) begin
                  t_r[j] <= (j == 4) ? x_r : y_r;
                end else if (func_r == F_SCALE && (j == 0 || j == 3)) begin
                  t_r[j] <= (j == 0) ? x_r : y_r;
                end else begin
                  t_r[j] <= ident(j);
                end
              end
              wr_cur_r <= !sup_r;
              state_r  <= (func_r == F_ROTATE) ? S_CORDIC_GO : S_PASS_MUL;
            end
            F_CONCAT: begin
              for (int j = 0; j < 6; j++) begin
                src_r[j] <= cur_r[j];
                t_r[j]   <= m_r[j];
              end
              wr_cur_r <= 1'b1;
              state_r  <= S_PASS_MUL;
            end
            F_TRANSFORM, F_DTRANSFORM: begin
              for (int j = 0; j < 6; j++) begin
                src_r[j] <= sup_r ? m_r[j] : cur_r[j];
                res_r[j] <= '0;
              end
              t_r[0]  <= x_r;
              t_r[1]  <= y_r;
              state_r <= S_PASS_MUL;
            end
            F_ITRANSFORM, F_IDTRANSFORM, F_INVERT: begin
              if (sup_r) begin
                for (int j = 0; j < 6; j++) begin
                  src_r[j] <= m_r[j];
                end
                state_r <= S_DET_MUL;
              end else if (inv_valid_r) begin
                for (int j = 0; j < 6; j++) begin
                  res_r[j] <= inv_r[j];
                end
                state_r <= S_INV_DONE;
              end else begin
                for (int j = 0; j < 6; j++) begin
                  src_r[j] <= cur_r[j];
                end
                state_r <= S_DET_MUL;
              end
            end
            default: begin
              for (int j = 0; j < 6; j++) begin
                res_r[j] <= '0;
              end
              state_r <= S_FIN;
            end
          endcase
        end
        S_CORDIC_GO: state_r <= S_CORDIC_WAIT;
        S_CORDIC_WAIT: begin
          if (!cordic_busy) begin
            t_r[0]  <= cos_v;
            t_r[1]  <= sin_v;
            t_r[2]  <= sneg(sin_v);
            t_r[3]  <= cos_v;
            state_r <= S_PASS_MUL;
          end
        end
        S_PASS_MUL: state_r <= S_PASS_MRG;
        S_PASS_MRG: state_r <= S_PASS_WB;
        S_PASS_WB: begin
          case (dst_r)
            2'd0: begin
              res_r[0] <= mrg_r0;
              res_r[1] <= mrg_r1;
            end
            2'd1: begin
              res_r[2] <= mrg_r0;
              res_r[3] <= mrg_r1;
            end
            default: begin
              res_r[4] <= mrg_r0;
              res_r[5] <= mrg_r1;
            end
          endcase
          case (job_r)
            J_MAT: begin
              if (coef_r == 2'd2) begin
                state_r <= S_MAT_END;
              end else begin
                coef_r  <= coef_r + 1'b1;
                dst_r   <= dst_r + 1'b1;
                state_r <= S_PASS_MUL;
              end
            end
            J_INVT:  state_r <= S_INV_DONE;
            default: state_r <= S_FIN;
          endcase
        end
        S_MAT_END: begin
          if (wr_cur_r) begin
            for (int j = 0; j < 6; j++) begin
              cur_r[j] <= res_r[j];
            end
            inv_valid_r <= 1'b0;
          end
          state_r <= S_FIN;
        end
        S_DET_MUL: state_r <= S_DET_MRG;
        S_DET_MRG: state_r <= S_DET_CHK;
        S_DET_CHK: begin
          if (mrg_r0 == '0) begin
            st_r <= 1'b1;
            for (int j = 0; j < 6; j++) begin
              res_r[j] <= '0;
            end
            state_r <= S_FIN;
          end else begin
            det_r   <= mrg_r0;
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (!(|lane_busy)) begin
            res_r[0] <= lane_quo[0];
            res_r[1] <= sneg(lane_quo[1]);
            res_r[2] <= sneg(lane_quo[2]);
            res_r[3] <= lane_quo[3];
            src_r[0] <= lane_quo[0];
            src_r[1] <= sneg(lane_quo[1]);
            src_r[2] <= sneg(lane_quo[2]);
            src_r[3] <= lane_quo[3];
            t_r[0]   <= src_r[4];
            t_r[1]   <= src_r[5];
            job_r    <= J_INVT;
            coef_r   <= 2'd0;
            dst_r    <= 2'd2;
            state_r  <= S_PASS_MUL;
          end
        end
        S_INV_DONE: begin
          if (!sup_r) begin
            for (int j = 0; j < 6; j++) begin
              inv_r[j] <= res_r[j];
            end
            inv_valid_r <= 1'b1;
          end
          if (func_r == F_INVERT) begin
            state_r <= S_FIN;
          end else begin
            for (int j = 0; j < 6; j++) begin
              src_r[j] <= res_r[j];
              res_r[j] <= '0;
            end
            t_r[0]  <= x_r;
            t_r[1]  <= y_r;
            job_r   <= J_MAP;
            coef_r  <= 2'd0;
            dst_r   <= 2'd0;
            add_r   <= func_r == F_ITRANSFORM;
            state_r <= S_PASS_MUL;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            for (int j = 0; j < 6; j++) begin
              out_res_r[j] <= res_r[j];
            end
            out_st_r    <= st_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/acm_checker.sv
// Port-level checker for the affine transform-matrix engine and its bind
// to the top level. Depends on acm_pkg and affine_ctm_engine_top.
module acm_checker import acm_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input logic  out_status,
  input word_t res_a,
  input word_t res_b,
  input word_t res_c,
  input word_t res_d,
  input word_t res_tx,
  input word_t res_ty
);

  // After a transfer in, the engine is busy with that operation.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an operation is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_a) && $stable(out_status))
    else $error("stalled result changed");

  // A singular matrix yields all-zero words.
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> res_a == '0 && res_b == '0 && res_c == '0 &&
      res_d == '0 && res_tx == '0 && res_ty == '0)
    else $error("nonzero words with undefined-result status");

  // A new result only appears at the end of an operation.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an operation in work");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind affine_ctm_engine_top acm_checker u_acm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_status(out_ch.status),
  .res_a     (out_ch.res_a),
  .res_b     (out_ch.res_b),
  .res_c     (out_ch.res_c),
  .res_d     (out_ch.res_d),
  .res_tx    (out_ch.res_tx),
  .res_ty    (out_ch.res_ty)
);
